>>> hw/rtl/touch_calibrate_average_macros.svh
// assertion macros for the touch calibration block
`ifndef TOUCH_CALIBRATE_AVERAGE_MACROS_SVH
`define TOUCH_CALIBRATE_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define TCA_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TCA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define TCA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> hw/rtl/tca_pkg.sv
// types and constants shared by the touch calibration block
`timescale 1ns / 1ps
package tca_pkg;
   localparam int AVG_DEPTH = 4;
   localparam int CNT_W = $clog2(AVG_DEPTH + 1);
   localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam logic [8:0] SCREEN_W = 9'd240;
   localparam logic [8:0] SCREEN_H = 9'd320;
   localparam logic [2:0] REG_X_MIN = 3'd0;
   localparam logic [2:0] REG_X_MAX = 3'd1;
   localparam logic [2:0] REG_Y_MIN = 3'd2;
   localparam logic [2:0] REG_Y_MAX = 3'd3;
   localparam logic [2:0] REG_SWAP = 3'd4;
   localparam logic [2:0] REG_INV_X = 3'd5;
   localparam logic [2:0] REG_INV_Y = 3'd6;

   typedef struct packed {
      logic        pen_down;
      logic [15:0] raw_x_word;
      logic [15:0] raw_y_word;
   } req_type;

   typedef struct packed {
      logic [7:0] coord_x;
      logic [8:0] coord_y;
      logic       touch_valid;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        pen_down;
      logic [11:0] off_x;
      logic [11:0] span_x;
      logic        sat_x;
      logic [11:0] off_y;
      logic [11:0] span_y;
      logic        sat_y;
   } job_type;
endpackage

>>> hw/rtl/tca_front.sv
// front: accepts items, extracts readings, applies swap and offsets, queues jobs
`timescale 1ns / 1ps
module tca_front import tca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic [11:0] x_min,
   input  logic [11:0] x_max,
   input  logic [11:0] y_min,
   input  logic [11:0] y_max,
   input  logic        swap,
   output logic        job_valid,
   input  logic        job_take,
   output job_type     job_data
);
   job_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic [11:0] rx, ry, ax, ay;
   job_type    job;
   logic       push, pop;

   // reading extraction and axis correction
   always_comb begin
      rx = swap ? req_data.raw_y_word[14:3] : req_data.raw_x_word[14:3];
      ry = swap ? req_data.raw_x_word[14:3] : req_data.raw_y_word[14:3];
      ax = rx;
      ay = ry;
      job.pen_down = req_data.pen_down;
      job.off_x = (ax > x_min) ? ax - x_min : 12'd0;
      job.off_y = (ay > y_min) ? ay - y_min : 12'd0;
      job.sat_x = (x_max <= x_min);
      job.sat_y = (y_max <= y_min);
      job.span_x = x_max - x_min;
      job.span_y = y_max - y_min;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = job_valid && job_take;
   assign job_valid = (cnt_ff != 2'd0);
   assign job_data = q_ff[rp_ff];

   // two-entry job queue
   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
      if (push) q_ff[wp_ff] <= job;
   end
endmodule

>>> hw/rtl/tca_back.sv
// back: shared serial divider, mirroring, history and mean
`timescale 1ns / 1ps
`include "touch_calibrate_average_macros.svh"
module tca_back import tca_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_take,
   input  job_type    job_data,
   input  logic       inv_x,
   input  logic       inv_y,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIVX = 3'd1;
   localparam logic [2:0] ST_DIVY = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_MEAN = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  st_ff;
   job_type     job_ff;
   logic [20:0] num_ff;   // dividend shifting out the top
   logic [11:0] rem_ff;
   logic [19:0] quo_ff;
   logic [4:0]  bit_ff;
   logic [8:0]  vx_ff;
   logic [7:0]  hx_ff [AVG_DEPTH];
   logic [8:0]  hy_ff [AVG_DEPTH];
   logic [CNT_W-1:0] cnt_ff;
   logic [7:0]  held_x_ff;
   logic [8:0]  held_y_ff;
   logic [IDX_W+8:0] sx_ff;
   logic [IDX_W+9:0] sy_ff;
   logic [CNT_W-1:0] si_ff;
   logic [CNT_W-1:0] remx_ff, remy_ff;
   logic        rv_ff;
   rsp_type     rd_ff;
   logic [13:0] trial;
   logic [12:0] rem_sh;
   logic [11:0] dvs;
   logic [8:0]  q_sat, full, mir;
   logic        do_inv;
   logic [CNT_W:0]   remx_sh, remy_sh;
   logic [CNT_W+1:0] trialx, trialy;

   assign job_take = (st_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

   // one restoring division step per cycle
   always_comb begin
      dvs = (st_ff == ST_DIVX) ? job_ff.span_x : job_ff.span_y;
      rem_sh = {rem_ff, num_ff[20]};
      trial = {1'b0, rem_sh} - {2'b0, dvs};
      full = (st_ff == ST_DIVX) ? SCREEN_W : SCREEN_H;
      do_inv = (st_ff == ST_DIVX) ? inv_x : inv_y;
      if (((st_ff == ST_DIVX) ? job_ff.sat_x : job_ff.sat_y) ||
          ({quo_ff, !trial[13]} > {12'd0, full}))
         q_sat = full;
      else
         q_sat = {quo_ff[7:0], !trial[13]};
      mir = do_inv ? full - q_sat : q_sat;
   end

   // mean step: both sums divided by the count, one quotient bit per cycle
   always_comb begin
      remx_sh = {remx_ff, sx_ff[IDX_W+8]};
      remy_sh = {remy_ff, sy_ff[IDX_W+9]};
      trialx = {1'b0, remx_sh} - {2'b0, cnt_ff};
      trialy = {1'b0, remy_sh} - {2'b0, cnt_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
         held_x_ff <= 8'd0;
         held_y_ff <= 9'd0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            hx_ff[i] <= 8'd0;
            hy_ff[i] <= 9'd0;
         end
      end else begin
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (job_valid && job_take) begin
                  job_ff <= job_data;
                  if (!job_data.pen_down) begin
                     cnt_ff <= '0;
                     rd_ff <= '{held_x_ff, held_y_ff, 1'b0};
                     rv_ff <= 1'b1;
                  end else begin
                     num_ff <= 21'(job_data.off_x) * 21'(SCREEN_W);
                     rem_ff <= '0;
                     quo_ff <= '0;
                     bit_ff <= 5'd0;
                     st_ff <= ST_DIVX;
                  end
               end
            end
            ST_DIVX, ST_DIVY: begin
               if (bit_ff == 5'd20) begin
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= 5'd0;
                  if (st_ff == ST_DIVX) begin
                     vx_ff <= mir;
                     num_ff <= 21'(job_ff.off_y) * 21'(SCREEN_H);
                     st_ff <= ST_DIVY;
                  end else begin
                     for (int i = AVG_DEPTH - 1; i > 0; i--) begin
                        hx_ff[i] <= hx_ff[i-1];
                        hy_ff[i] <= hy_ff[i-1];
                     end
                     hx_ff[0] <= vx_ff[7:0];
                     hy_ff[0] <= mir;
                     if (cnt_ff < CNT_W'(AVG_DEPTH)) cnt_ff <= cnt_ff + 1'b1;
                     sx_ff <= '0;
                     sy_ff <= '0;
                     si_ff <= '0;
                     st_ff <= ST_SUM;
                  end
               end else begin
                  num_ff <= {num_ff[19:0], 1'b0};
                  rem_ff <= trial[13] ? rem_sh[11:0] : trial[11:0];
                  quo_ff <= {quo_ff[18:0], !trial[13]};
                  bit_ff <= bit_ff + 5'd1;
               end
            end
            ST_SUM: begin
               // one history entry per cycle
               if (si_ff == cnt_ff) begin
                  remx_ff <= '0;
                  remy_ff <= '0;
                  bit_ff <= 5'd0;
                  st_ff <= ST_MEAN;
               end else begin
                  sx_ff <= sx_ff + (IDX_W+9)'(hx_ff[si_ff[IDX_W-1:0]]);
                  sy_ff <= sy_ff + (IDX_W+10)'(hy_ff[si_ff[IDX_W-1:0]]);
                  si_ff <= si_ff + 1'b1;
               end
            end
            ST_MEAN: begin
               // quotient bits shift into the sums, x lane is one bit narrower
               if (bit_ff < 5'(IDX_W + 9)) begin
                  sx_ff <= {sx_ff[IDX_W+7:0], !trialx[CNT_W+1]};
                  remx_ff <= trialx[CNT_W+1] ? remx_sh[CNT_W-1:0] : trialx[CNT_W-1:0];
               end
               sy_ff <= {sy_ff[IDX_W+8:0], !trialy[CNT_W+1]};
               remy_ff <= trialy[CNT_W+1] ? remy_sh[CNT_W-1:0] : trialy[CNT_W-1:0];
               if (bit_ff == 5'(IDX_W + 9)) begin
                  bit_ff <= 5'd0;
                  st_ff <= ST_OUT;
               end else begin
                  bit_ff <= bit_ff + 5'd1;
               end
            end
            ST_OUT: begin
               held_x_ff <= sx_ff[7:0];
               held_y_ff <= sy_ff[8:0];
               rd_ff <= '{sx_ff[7:0], sy_ff[8:0], 1'b1};
               rv_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   `TCA_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CNT_W'(AVG_DEPTH), "count overflow")
   `TCA_ASSERT_IMPL(a_no_take_busy, clock, reset, (st_ff != ST_IDLE) |-> !job_take, "take while busy")
   `TCA_ASSERT_IMPL(a_out_valid, clock, reset, (st_ff == ST_OUT) |=> rsp_valid && rsp_data.touch_valid, "missing result")
endmodule

>>> hw/rtl/touch_calibrate_average.sv
// touch calibration top level: register file, front and back
// the back takes a new item only when idle and no result is waiting, and holds
// a serial divider (21 steps per axis), a history sum (one entry per cycle)
// and a mean division (12 steps); a two-item queue sits between front and back
// reset: synchronous active high, registers to defaults, history and held point to zero
`timescale 1ns / 1ps
module touch_calibrate_average import tca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   logic [11:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic        swap_ff, inv_x_ff, inv_y_ff;
   logic        job_valid, job_take;
   job_type     job_data;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= 12'd0;
         x_max_ff <= 12'd4095;
         y_min_ff <= 12'd0;
         y_max_ff <= 12'd4095;
         swap_ff <= 1'b0;
         inv_x_ff <= 1'b0;
         inv_y_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_MIN: x_min_ff <= csr_wdata;
            REG_X_MAX: x_max_ff <= csr_wdata;
            REG_Y_MIN: y_min_ff <= csr_wdata;
            REG_Y_MAX: y_max_ff <= csr_wdata;
            REG_SWAP:  swap_ff <= csr_wdata[0];
            REG_INV_X: inv_x_ff <= csr_wdata[0];
            REG_INV_Y: inv_y_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tca_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .x_min(x_min_ff), .x_max(x_max_ff), .y_min(y_min_ff), .y_max(y_max_ff),
      .swap(swap_ff), .job_valid, .job_take, .job_data
   );

   tca_back u_back (
      .clock, .reset, .job_valid, .job_take, .job_data,
      .inv_x(inv_x_ff), .inv_y(inv_y_ff), .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
